// ===== rtl/core/ctsb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsb_pkg
// shared types and constants of the cartesian tree stack builder
// ----------------------------------------------------------------------------
package ctsb_pkg;

    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int WEIGHT_W  = 32;
    localparam int OUT_IDX_W = 10;
    localparam int ENTRY_W   = WEIGHT_W + IDX_W;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       start_new;
    } t_in_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] node_index;
        logic                 has_left;
        logic [OUT_IDX_W-1:0] left_child;
        logic                 has_parent;
        logic [OUT_IDX_W-1:0] parent_index;
        logic [OUT_IDX_W-1:0] root_index;
        logic                 overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic [IDX_W-1:0]           idx;
    } t_entry;

endpackage

// ===== rtl/core/ctsb_if.sv =====
// ----------------------------------------------------------------------------
// ctsb_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface ctsb_in_if;
    logic              valid;
    logic              ready;
    ctsb_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctsb_out_if;
    logic               valid;
    logic               ready;
    ctsb_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ctsb_ram.sv =====
// ----------------------------------------------------------------------------
// ctsb_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ctsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cartesian_tree_stack_builder_unit.sv =====
// ----------------------------------------------------------------------------
// cartesian_tree_stack_builder_unit
// min-rooted cartesian tree builder over a stream of signed weights
// ----------------------------------------------------------------------------
// Each accepted weight becomes node next_index; stacked entries with a weight
// greater than or equal to it are popped (ties go left), the last popped one
// becomes its left child and the remaining top becomes its parent. The stack
// lives in one ram with a registered read, walked one entry per cycle. An
// item that finds the stack empty or capacity exceeded has its result
// registered in the cycle it is accepted; otherwise the accept cycle reads
// the top entry and the walk compares entries, popping while they are not
// smaller, until one stops it or the stack empties. Every node is pushed
// once and popped at most once; no new item is taken during the walk.
// A start_new item clears the stack and restarts numbering at zero;
// once MAX_NODES nodes are numbered, items are dropped with overflow set.
// One result register holds the finished result; the next item is taken in
// the cycle the result is taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module cartesian_tree_stack_builder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctsb_in_if.sink     i_in_ch,
    ctsb_out_if.source  o_out_ch
);
    import ctsb_pkg::*;

    typedef enum logic {S_IDLE, S_WALK} t_state;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_depth, n_depth;
    logic [CNT_W-1:0]           r_next, n_next;
    logic [IDX_W-1:0]           r_root, n_root;
    logic [CNT_W-1:0]           r_d, n_d;
    logic signed [WEIGHT_W-1:0] r_weight, n_weight;
    logic [IDX_W-1:0]           r_node, n_node;
    logic                       r_has_left, n_has_left;
    logic [IDX_W-1:0]           r_left, n_left;
    t_out_item                  r_out, n_out;
    logic                       r_ovalid, n_ovalid;

    logic             w_in_ready;
    logic             w_accept;
    logic [CNT_W-1:0] w_eff_depth;
    logic [CNT_W-1:0] w_eff_next;
    logic [CNT_W-1:0] w_dec;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wentry;
    logic             w_re;
    logic [IDX_W-1:0] w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry           w_rentry;

    assign w_in_ready = (r_state == S_IDLE) && (!r_ovalid || o_out_ch.ready);
    assign w_accept   = w_in_ready && i_in_ch.valid;
    assign w_rentry   = t_entry'(w_rdata);
    assign w_dec      = r_d - CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_next     = r_next;
        n_root     = r_root;
        n_d        = r_d;
        n_weight   = r_weight;
        n_node     = r_node;
        n_has_left = r_has_left;
        n_left     = r_left;
        n_out      = r_out;
        n_ovalid   = r_ovalid && !o_out_ch.ready;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wentry   = '0;
        w_re       = 1'b0;
        w_raddr    = '0;
        w_eff_depth = i_in_ch.data.start_new ? '0 : r_depth;
        w_eff_next  = i_in_ch.data.start_new ? '0 : r_next;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_depth    = w_eff_depth;
                    n_next     = w_eff_next;
                    n_weight   = i_in_ch.data.weight;
                    n_node     = w_eff_next[IDX_W-1:0];
                    n_has_left = 1'b0;
                    n_left     = '0;
                    if (w_eff_next >= CNT_W'(MAX_NODES)) begin
                        n_out            = '0;
                        n_out.overflow   = 1'b1;
                        n_out.root_index = (w_eff_depth != '0) ?
                                           OUT_IDX_W'(r_root) : '0;
                        n_ovalid         = 1'b1;
                    end else if (w_eff_depth == '0) begin
                        w_we             = 1'b1;
                        w_waddr          = '0;
                        w_wentry.weight  = i_in_ch.data.weight;
                        w_wentry.idx     = w_eff_next[IDX_W-1:0];
                        n_root           = w_eff_next[IDX_W-1:0];
                        n_depth          = CNT_W'(1);
                        n_next           = w_eff_next + CNT_W'(1);
                        n_out            = '0;
                        n_out.node_index = OUT_IDX_W'(w_eff_next[IDX_W-1:0]);
                        n_out.root_index = OUT_IDX_W'(w_eff_next[IDX_W-1:0]);
                        n_ovalid         = 1'b1;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = IDX_W'(w_eff_depth - CNT_W'(1));
                        n_d     = w_eff_depth;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_weight <= w_rentry.weight) begin
                    n_has_left = 1'b1;
                    n_left     = w_rentry.idx;
                    n_d        = w_dec;
                    if (w_dec == '0) begin
                        w_we               = 1'b1;
                        w_waddr            = '0;
                        w_wentry.weight    = r_weight;
                        w_wentry.idx       = r_node;
                        n_root             = r_node;
                        n_depth            = CNT_W'(1);
                        n_next             = r_next + CNT_W'(1);
                        n_out              = '0;
                        n_out.node_index   = OUT_IDX_W'(r_node);
                        n_out.has_left     = 1'b1;
                        n_out.left_child   = OUT_IDX_W'(w_rentry.idx);
                        n_out.root_index   = OUT_IDX_W'(r_node);
                        n_ovalid           = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = IDX_W'(w_dec - CNT_W'(1));
                    end
                end else begin
                    w_we               = 1'b1;
                    w_waddr            = r_d[IDX_W-1:0];
                    w_wentry.weight    = r_weight;
                    w_wentry.idx       = r_node;
                    n_depth            = r_d + CNT_W'(1);
                    n_next             = r_next + CNT_W'(1);
                    n_out              = '0;
                    n_out.node_index   = OUT_IDX_W'(r_node);
                    n_out.has_left     = r_has_left;
                    n_out.left_child   = OUT_IDX_W'(r_left);
                    n_out.has_parent   = 1'b1;
                    n_out.parent_index = OUT_IDX_W'(w_rentry.idx);
                    n_out.root_index   = OUT_IDX_W'(r_root);
                    n_ovalid           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_next   <= '0;
            r_root   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_next   <= n_next;
            r_root   <= n_root;
            r_ovalid <= n_ovalid;
        end
        r_d        <= n_d;
        r_weight   <= n_weight;
        r_node     <= n_node;
        r_has_left <= n_has_left;
        r_left     <= n_left;
        r_out      <= n_out;
    end

    // stack storage
    ctsb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (ENTRY_W'(w_wentry)),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in_ch.ready  = w_in_ready;
    assign o_out_ch.valid = r_ovalid;
    assign o_out_ch.data  = r_out;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for cartesian_tree_stack_builder_unit
// ----------------------------------------------------------------------------
// Weights are driven on the input channel with random gaps. Every accepted
// transfer runs through a local monotonic-stack model of the tree, and its
// link update is queued. Each result transfer is compared field by field
// with the oldest queued update. The tests cover hand-picked link patterns,
// filling every node index and overflow, a long receiver hold-off with
// a drained pause, and random runs of weights.
// ----------------------------------------------------------------------------
module tb;
    import ctsb_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = MAX_NODES + 16;
    localparam int RANDOM_ITEMS  = 200;
    localparam int HOLD_CYCLES   = 400;

    logic clk;
    logic rst_n;

    ctsb_in_if  in_ch ();
    ctsb_out_if out_ch ();

    cartesian_tree_stack_builder_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    logic signed [WEIGHT_W-1:0] tree_key [MAX_NODES];
    logic [IDX_W-1:0]           tree_idx [MAX_NODES];
    int                         tree_depth = 0;
    int                         node_count = 0;

    t_out_item pending_links [$];
    int        fail_count  = 0;
    int        cycle_count = 0;
    int        hold_left   = 0;
    bit        no_idle     = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // tree model: one link update per transfer
    function automatic t_out_item link_node(input logic signed [WEIGHT_W-1:0] w,
                                            input logic s);
        t_out_item r;
        int        d;
        r = '0;
        if (s) begin
            tree_depth = 0;
            node_count = 0;
        end
        if (node_count >= MAX_NODES) begin
            r.overflow = 1'b1;
        end else begin
            d = tree_depth;
            while (d > 0 && w <= tree_key[d-1]) begin
                r.has_left   = 1'b1;
                r.left_child = tree_idx[d-1][OUT_IDX_W-1:0];
                d--;
            end
            if (d > 0) begin
                r.has_parent   = 1'b1;
                r.parent_index = tree_idx[d-1][OUT_IDX_W-1:0];
            end
            r.node_index = node_count[OUT_IDX_W-1:0];
            tree_key[d]  = w;
            tree_idx[d]  = node_count[IDX_W-1:0];
            tree_depth   = d + 1;
            node_count++;
        end
        if (tree_depth > 0)
            r.root_index = tree_idx[0][OUT_IDX_W-1:0];
        return r;
    endfunction

    task automatic send_weight(input logic signed [WEIGHT_W-1:0] w, input logic s);
        while (!no_idle && $urandom_range(99) < 36) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {w, s};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_links.push_back(link_node(w, s));
    endtask

    task automatic wait_links_done();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_links.size() != 0);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // receiver side
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= no_idle || ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out_item exp_link;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_links.size() == 0) begin
                $error("result transfer with no expected update");
                fail_count++;
            end else begin
                exp_link = pending_links.pop_front();
                check_field("node_index", int'(exp_link.node_index),
                            int'(out_ch.data.node_index));
                check_field("has_left", int'(exp_link.has_left),
                            int'(out_ch.data.has_left));
                check_field("left_child", int'(exp_link.left_child),
                            int'(out_ch.data.left_child));
                check_field("has_parent", int'(exp_link.has_parent),
                            int'(out_ch.data.has_parent));
                check_field("parent_index", int'(exp_link.parent_index),
                            int'(out_ch.data.parent_index));
                check_field("root_index", int'(exp_link.root_index),
                            int'(out_ch.data.root_index));
                check_field("overflow", int'(exp_link.overflow),
                            int'(out_ch.data.overflow));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL cartesian_tree_stack_builder_unit");
            $finish;
        end
    end

    task automatic test_tree_links();
        send_weight(32'sd5, 1'b0);
        send_weight(32'sd3, 1'b0);
        send_weight(32'sd3, 1'b0);
        send_weight(32'sd7, 1'b0);
        send_weight(32'sd9, 1'b0);
        send_weight(32'sd8, 1'b0);
        send_weight(32'sh7fffffff, 1'b0);
        send_weight(32'sh80000000, 1'b0);
        send_weight(32'sh80000000, 1'b0);
        send_weight(32'sh7fffffff, 1'b0);
        send_weight(-32'sd1, 1'b0);
        send_weight(32'sd0, 1'b0);
        send_weight(-32'sd1, 1'b1);
        send_weight(32'sd0, 1'b1);
        send_weight(32'sd1, 1'b0);
        send_weight(32'sd2, 1'b0);
        send_weight(32'sd3, 1'b0);
        send_weight(-32'sd5, 1'b0);
        send_weight(32'sh55555555, 1'b0);
        send_weight(32'shaaaaaaaa, 1'b0);
        send_weight(32'sh55555555, 1'b0);
    endtask

    // fill every index, pop the whole stack, then run past capacity
    task automatic test_capacity();
        no_idle = 1'b1;
        send_weight(-32'sd2000, 1'b1);
        for (int i = 1; i < MAX_NODES - 1; i++)
            send_weight(-32'sd2000 + i, 1'b0);
        send_weight(32'sh80000000, 1'b0);
        no_idle = 1'b0;
        repeat (3)
            send_weight($urandom, 1'b0);
        send_weight($urandom, 1'b1);
        send_weight($urandom, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_links_done();
        hold_left = HOLD_CYCLES;
        no_idle   = 1'b1;
        for (int i = 0; i < 30; i++)
            send_weight($urandom_range(40) - 20, (i == 0));
        no_idle = 1'b0;
        wait_links_done();
        for (int i = 0; i < 10; i++)
            send_weight($urandom, 1'b0);
    endtask

    task automatic test_random_runs();
        int                         sent;
        int                         len;
        int                         mode;
        int                         step;
        logic                       first_start;
        logic                       s;
        logic signed [WEIGHT_W-1:0] base;
        logic signed [WEIGHT_W-1:0] w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len         = $urandom_range(60, 1);
            mode        = $urandom_range(4);
            step        = $urandom_range(1000, 1);
            base        = $urandom;
            first_start = ($urandom_range(4) != 0);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: w = $urandom;
                    1: w = $urandom_range(8) - 4;
                    2: w = base + i * step;
                    3: w = base - i * step;
                    default: begin
                        case ($urandom_range(3))
                            0: w = 32'sh80000000;
                            1: w = 32'sh7fffffff;
                            2: w = $urandom_range(2) - 1;
                            default: w = $urandom;
                        endcase
                    end
                endcase
                s = (i == 0) ? first_start : ($urandom_range(49) == 0);
                send_weight(w, s);
                sent++;
            end
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tree_links();
        test_capacity();
        test_backpressure();
        test_random_runs();

        wait_links_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_links.size() == 0) begin
            $display("PASS cartesian_tree_stack_builder_unit");
        end else begin
            $display("FAIL cartesian_tree_stack_builder_unit");
        end
        $finish;
    end
endmodule
